### src/gpcl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpcl_pkg
// Shared types, register codes and helpers for the GPIO port with
// configuration lock.
// ----------------------------------------------------------------------------
package gpcl_pkg;

  localparam int unsigned NUM_PINS   = 16;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned FIELD_W    = 4;
  localparam int unsigned HALF_PINS  = 8;
  localparam int unsigned KEY_POS    = 16;

  localparam logic [DATA_W-1:0] MODE_RESET = 32'h4444_4444;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [IDX_W-1:0] REG_CRL  = 3'd0;
  localparam logic [IDX_W-1:0] REG_CRH  = 3'd1;
  localparam logic [IDX_W-1:0] REG_IDR  = 3'd2;
  localparam logic [IDX_W-1:0] REG_ODR  = 3'd3;
  localparam logic [IDX_W-1:0] REG_BSRR = 3'd4;
  localparam logic [IDX_W-1:0] REG_BRR  = 3'd5;
  localparam logic [IDX_W-1:0] REG_LCKR = 3'd6;

  typedef struct packed {
    logic                command;
    logic [IDX_W-1:0]    reg_index;
    logic [DATA_W-1:0]   write_data;
    logic [NUM_PINS-1:0] pin_levels;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0]   read_data;
    logic [NUM_PINS-1:0] pin_drive;
    logic                lock_active;
  } out_item_t;

  typedef struct packed {
    logic                key;
    logic                key_nxt;
    logic [NUM_PINS-1:0] bits;
  } lock_status_t;

  // expand one lock bit per pin into a 4-bit field mask per pin
  function automatic logic [DATA_W-1:0] nibble_mask(input logic [HALF_PINS-1:0] bits8);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int i = 0; i < HALF_PINS; i++) begin
      m[i*FIELD_W +: FIELD_W] = {FIELD_W{bits8[i]}};
    end
    return m;
  endfunction

endpackage

### src/gpio_port_with_config_lock.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpio_port_with_config_lock
// 16-pin GPIO port register block with a lock key sequence on its mode
// registers.
// ----------------------------------------------------------------------------
// One bus access is taken per clock cycle while in_stall is low. An accepted
// access sits in an input register, is executed against the register state
// in a single pass of logic, and its result lands in an output register. The
// output register holds a result while out_stall is high; in_stall rises only
// when both the input and output registers are full and the output is stalled.
// Each result carries the read value (zero for writes), and the output data
// register and the lock flag as they stand after that access.
module gpio_port_with_config_lock (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  gpcl_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output gpcl_pkg::out_item_t out_item
);

  logic                   s1_valid_r, s1_valid_nxt;
  gpcl_pkg::in_item_t     s1_item_r;
  logic                   out_valid_r, out_valid_nxt;
  gpcl_pkg::out_item_t    out_item_r;
  logic                   fire;
  logic                   in_xfer;
  gpcl_pkg::lock_status_t status;
  gpcl_pkg::out_item_t    result;

  assign fire          = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall      = s1_valid_r && !fire;
  assign in_xfer       = in_valid && !in_stall;
  assign s1_valid_nxt  = in_xfer || (s1_valid_r && !fire);
  assign out_valid_nxt = fire || (out_valid_r && out_stall);

  gpcl_lock u_lock (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (s1_item_r),
    .status (status)
  );

  gpcl_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (s1_item_r),
    .status (status),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r <= in_item;
    end
    if (fire) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### src/gpcl_lock.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpcl_lock
// Lock register and key sequencer: tracks the write/write/write/read key
// sequence and freezes the lock bits once the lock is active.
// ----------------------------------------------------------------------------
module gpcl_lock (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  gpcl_pkg::in_item_t  item,
  output gpcl_pkg::lock_status_t status
);

  localparam logic [1:0] STEP_IDLE = 2'd0;
  localparam logic [1:0] STEP_ONE  = 2'd1;
  localparam logic [1:0] STEP_TWO  = 2'd2;
  localparam logic [1:0] STEP_SEAL = 2'd3;

  logic [1:0]                     step_r, step_nxt;
  logic                           key_r, key_nxt;
  logic [gpcl_pkg::NUM_PINS-1:0]  bits_r, bits_nxt;
  logic                           wr_key;
  logic                           same;
  logic                           lckr_hit;

  assign wr_key   = item.write_data[gpcl_pkg::KEY_POS];
  assign same     = (item.write_data[gpcl_pkg::NUM_PINS-1:0] == bits_r);
  assign lckr_hit = fire && !key_r && (item.reg_index == gpcl_pkg::REG_LCKR);

  always_comb begin
    step_nxt = step_r;
    key_nxt  = key_r;
    bits_nxt = bits_r;
    if (lckr_hit) begin
      if (item.command == gpcl_pkg::CMD_WRITE) begin
        bits_nxt = item.write_data[gpcl_pkg::NUM_PINS-1:0];
        if (step_r == STEP_ONE && !wr_key && same) begin
          step_nxt = STEP_TWO;
        end else if (step_r == STEP_TWO && wr_key && same) begin
          step_nxt = STEP_SEAL;
        end else begin
          step_nxt = wr_key ? STEP_ONE : STEP_IDLE;
        end
      end else begin
        if (step_r == STEP_SEAL) begin
          key_nxt = 1'b1;
        end
        step_nxt = STEP_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_IDLE;
      key_r  <= 1'b0;
      bits_r <= '0;
    end else begin
      step_r <= step_nxt;
      key_r  <= key_nxt;
      bits_r <= bits_nxt;
    end
  end

  assign status.key     = key_r;
  assign status.key_nxt = key_nxt;
  assign status.bits    = bits_r;

  a_lock_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    key_r |=> key_r) else $error("lock cleared without reset");

  a_locked_idle: assert property (@(posedge clk) disable iff (!rst_n)
    key_r |-> step_r == STEP_IDLE) else $error("key sequence running under lock");

  a_bits_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    key_r |=> $stable(bits_r)) else $error("lock bits changed under lock");

  a_seal_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(key_r) |-> $past(step_r) == STEP_SEAL)
    else $error("lock activated outside final sequence step");

endmodule

### src/gpcl_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpcl_regs
// Mode and output data registers with the read mux; forms the result of
// each access: read data from before it, drive and lock flag from after it.
// ----------------------------------------------------------------------------
module gpcl_regs (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,
  input  gpcl_pkg::in_item_t     item,
  input  gpcl_pkg::lock_status_t status,
  output gpcl_pkg::out_item_t    result
);

  logic [gpcl_pkg::DATA_W-1:0]   mode_lo_r, mode_lo_nxt;
  logic [gpcl_pkg::DATA_W-1:0]   mode_hi_r, mode_hi_nxt;
  logic [gpcl_pkg::NUM_PINS-1:0] odr_r, odr_nxt;
  logic [gpcl_pkg::DATA_W-1:0]   keep_lo;
  logic [gpcl_pkg::DATA_W-1:0]   keep_hi;
  logic [gpcl_pkg::NUM_PINS-1:0] wd_lo;
  logic [gpcl_pkg::NUM_PINS-1:0] wd_hi;
  logic [gpcl_pkg::DATA_W-1:0]   rd;
  logic                          wr;

  assign wd_lo = item.write_data[gpcl_pkg::NUM_PINS-1:0];
  assign wd_hi = item.write_data[gpcl_pkg::DATA_W-1:gpcl_pkg::NUM_PINS];
  assign wr    = fire && (item.command == gpcl_pkg::CMD_WRITE);

  // locked fields keep their value only while the lock is active
  assign keep_lo = status.key ?
    gpcl_pkg::nibble_mask(status.bits[gpcl_pkg::HALF_PINS-1:0]) : '0;
  assign keep_hi = status.key ?
    gpcl_pkg::nibble_mask(status.bits[gpcl_pkg::NUM_PINS-1:gpcl_pkg::HALF_PINS]) : '0;

  always_comb begin
    mode_lo_nxt = mode_lo_r;
    mode_hi_nxt = mode_hi_r;
    odr_nxt     = odr_r;
    if (wr) begin
      case (item.reg_index)
        gpcl_pkg::REG_CRL:  mode_lo_nxt = (mode_lo_r & keep_lo) |
                                          (item.write_data & ~keep_lo);
        gpcl_pkg::REG_CRH:  mode_hi_nxt = (mode_hi_r & keep_hi) |
                                          (item.write_data & ~keep_hi);
        gpcl_pkg::REG_ODR:  odr_nxt = wd_lo;
        gpcl_pkg::REG_BSRR: odr_nxt = (odr_r & ~wd_hi) | wd_lo;
        gpcl_pkg::REG_BRR:  odr_nxt = odr_r & ~wd_lo;
        default:            odr_nxt = odr_r;
      endcase
    end
  end

  always_comb begin
    rd = '0;
    if (item.command == gpcl_pkg::CMD_READ) begin
      unique case (item.reg_index)
        gpcl_pkg::REG_CRL:  rd = mode_lo_r;
        gpcl_pkg::REG_CRH:  rd = mode_hi_r;
        gpcl_pkg::REG_IDR:  rd = {{(gpcl_pkg::DATA_W-gpcl_pkg::NUM_PINS){1'b0}},
                                  item.pin_levels};
        gpcl_pkg::REG_ODR:  rd = {{(gpcl_pkg::DATA_W-gpcl_pkg::NUM_PINS){1'b0}}, odr_r};
        gpcl_pkg::REG_LCKR: rd = {{(gpcl_pkg::DATA_W-gpcl_pkg::NUM_PINS-1){1'b0}},
                                  status.key, status.bits};
        default:            rd = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_lo_r <= gpcl_pkg::MODE_RESET;
      mode_hi_r <= gpcl_pkg::MODE_RESET;
      odr_r     <= '0;
    end else begin
      mode_lo_r <= mode_lo_nxt;
      mode_hi_r <= mode_hi_nxt;
      odr_r     <= odr_nxt;
    end
  end

  assign result.read_data   = rd;
  assign result.pin_drive   = odr_nxt;
  assign result.lock_active = status.key_nxt;

endmodule
